// ===== rtl/row_zscore_normalizer_assert.svh =====
// Assertion macros for the row z-score normalizer back end (rzn_back).
// Needs a clock named i_clk and an active-low reset named i_rst_n in scope.
`ifndef ROW_ZSCORE_NORMALIZER_ASSERT_SVH
`define ROW_ZSCORE_NORMALIZER_ASSERT_SVH

// Same-cycle implication, checked outside reset.
`define RZN_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, checked outside reset.
`define RZN_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge i_clk) disable iff (!i_rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ===== rtl/rzn_pkg.sv =====
// Shared constants for the row z-score normalizer.
// No dependencies.
package rzn_pkg;

    localparam int unsigned CFG_W    = 7;         // row_length register width
    localparam logic [6:0]  CFG_RST  = 7'd64;     // row_length after reset
    localparam int unsigned NORM_W   = 16;        // Q4.12 result width
    localparam int unsigned DIG_BITS = 4;         // quotient bits per divider cycle
    localparam int unsigned QZ_BITS  = 16;        // quotient bits of a normalized value

endpackage

// ===== rtl/rzn_ram.sv =====
// Generic simple dual-port RAM, one write and one registered read port.
// No dependencies.
module rzn_ram #(
    parameter int W     = 16,
    parameter int DEPTH = 128
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [W-1:0]             i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [W-1:0]             o_rdata
);

    logic [W-1:0] r_mem [DEPTH];
    logic [W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;

endmodule

// ===== rtl/rzn_queue.sv =====
// Two-entry queue of finished-row descriptors between front and back.
// No dependencies.
module rzn_queue #(
    parameter int W = 64
) (
    input  logic         i_clk,
    input  logic         i_rst_n,
    input  logic         i_push,
    input  logic [W-1:0] i_data,
    input  logic         i_pop,
    output logic [W-1:0] o_data,
    output logic         o_empty
);

    logic [W-1:0] r_mem [2];
    logic         r_wp;
    logic         r_rp;
    logic [1:0]   r_cnt;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wp  <= 1'b0;
            r_rp  <= 1'b0;
            r_cnt <= 2'd0;
        end else begin
            if (i_push) begin
                r_wp <= ~r_wp;
            end
            if (i_pop) begin
                r_rp <= ~r_rp;
            end
            r_cnt <= r_cnt + 2'(i_push) - 2'(i_pop);
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wp] <= i_data;
        end
    end

    assign o_data  = r_mem[r_rp];
    assign o_empty = (r_cnt == 2'd0);

endmodule

// ===== rtl/rzn_div.sv =====
// Restoring divider, DIG_BITS quotient bits per cycle, operands pre-aligned.
// Depends on rzn_pkg.
module rzn_div
    import rzn_pkg::*;
#(
    parameter int RW = 19,
    parameter int QW = 32,
    parameter int CW = 4
) (
    input  logic          i_clk,
    input  logic          i_rst_n,
    input  logic          i_start,
    input  logic [RW-1:0] i_rem,
    input  logic [QW-1:0] i_bits,
    input  logic [RW-2:0] i_den,
    input  logic [CW-1:0] i_digits,
    output logic          o_done,
    output logic [QW-1:0] o_quo
);

    logic [RW-1:0] r_rem, n_rem;
    logic [RW-2:0] r_den;
    logic [QW-1:0] r_bits, n_bits;
    logic [QW-1:0] r_quo, n_quo;
    logic [CW-1:0] r_cnt;
    logic          r_busy;
    logic          r_done;

    // Partial remainder stays below the divisor, so its top bit is free to shift.
    always_comb begin
        n_rem  = r_rem;
        n_bits = r_bits;
        n_quo  = r_quo;
        for (int j = 0; j < DIG_BITS; j++) begin
            n_rem  = {n_rem[RW-2:0], n_bits[QW-1]};
            n_bits = {n_bits[QW-2:0], 1'b0};
            if (n_rem >= {1'b0, r_den}) begin
                n_rem = n_rem - {1'b0, r_den};
                n_quo = {n_quo[QW-2:0], 1'b1};
            end else begin
                n_quo = {n_quo[QW-2:0], 1'b0};
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= i_digits;
            end else if (r_busy) begin
                r_cnt <= r_cnt - 1'b1;
                if (r_cnt == CW'(1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem  <= i_rem;
            r_bits <= i_bits;
            r_den  <= i_den;
            r_quo  <= '0;
        end else if (r_busy) begin
            r_rem  <= n_rem;
            r_bits <= n_bits;
            r_quo  <= n_quo;
        end
    end

    assign o_done = r_done;
    assign o_quo  = r_quo;

endmodule

// ===== rtl/rzn_front.sv =====
// Front end: takes samples into the row store, sums them and their squares,
// and queues a descriptor when a row closes. Depends on rzn_pkg.
module rzn_front
    import rzn_pkg::*;
#(
    parameter int ROW_MAX     = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic [CFG_W-1:0]                      i_row_len,
    input  logic                                  i_valid,
    output logic                                  o_ready,
    input  logic signed [SAMPLE_BITS-1:0]         i_sample,
    output logic                                  o_we,
    output logic [$clog2(ROW_MAX):0]              o_waddr,
    output logic [SAMPLE_BITS-1:0]                o_wdata,
    output logic                                  o_push,
    output logic [1+$clog2(ROW_MAX+1)+3*SAMPLE_BITS+2*$clog2(ROW_MAX)-1:0] o_desc,
    input  logic                                  i_row_done
);

    localparam int SB   = SAMPLE_BITS;
    localparam int LB   = $clog2(ROW_MAX);
    localparam int NB   = $clog2(ROW_MAX + 1);
    localparam int SUMW = SB + LB;
    localparam int SQW  = 2 * SB + LB;

    logic [NB-1:0]          r_fill, n_fill;
    logic signed [SUMW-1:0] r_sum, n_sum;
    logic [SQW-1:0]         r_sq, n_sq;
    logic                   r_bank;
    logic [1:0]             r_busy;
    logic [NB-1:0]          eff_len;
    logic [SB-1:0]          mag;
    logic                   accept;
    logic                   close;

    always_comb begin
        if (i_row_len == '0) begin
            eff_len = NB'(1);
        end else if (i_row_len > CFG_W'(ROW_MAX)) begin
            eff_len = NB'(ROW_MAX);
        end else begin
            eff_len = NB'(i_row_len);
        end
    end

    assign mag    = i_sample[SB-1] ? SB'(-i_sample) : SB'(i_sample);
    assign accept = i_valid && o_ready;
    assign n_fill = r_fill + 1'b1;
    assign n_sum  = r_sum + SUMW'(i_sample);
    assign n_sq   = r_sq + SQW'(mag * mag);
    assign close  = accept && (n_fill >= eff_len);

    // A bank stays busy from the push until the back end finishes its last result.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_fill <= '0;
            r_sum  <= '0;
            r_sq   <= '0;
            r_bank <= 1'b0;
            r_busy <= 2'd0;
        end else begin
            if (close) begin
                r_fill <= '0;
                r_sum  <= '0;
                r_sq   <= '0;
                r_bank <= ~r_bank;
            end else if (accept) begin
                r_fill <= n_fill;
                r_sum  <= n_sum;
                r_sq   <= n_sq;
            end
            r_busy <= r_busy + 2'(close) - 2'(i_row_done);
        end
    end

    assign o_ready = (r_busy < 2'd2);
    assign o_we    = accept;
    assign o_waddr = {r_bank, r_fill[LB-1:0]};
    assign o_wdata = i_sample;
    assign o_push  = close;
    assign o_desc  = {r_bank, n_fill, n_sum, n_sq};

endmodule

// ===== rtl/rzn_back.sv =====
// Back end: mean, variance and square root per row, then one rounded
// (x - mean) / std per stored sample. Depends on rzn_pkg, rzn_div and the macro header.
`include "row_zscore_normalizer_assert.svh"
module rzn_back
    import rzn_pkg::*;
#(
    parameter int ROW_MAX     = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  logic                                  i_empty,
    input  logic [1+$clog2(ROW_MAX+1)+3*SAMPLE_BITS+2*$clog2(ROW_MAX)-1:0] i_desc,
    output logic                                  o_pop,
    output logic [$clog2(ROW_MAX):0]              o_raddr,
    input  logic [SAMPLE_BITS-1:0]                i_rdata,
    output logic                                  o_row_done,
    input  logic                                  i_ready,
    output logic                                  o_valid,
    output logic signed [NORM_W-1:0]              o_norm_value,
    output logic                                  o_row_last,
    output logic                                  o_flat_row
);

    localparam int SB   = SAMPLE_BITS;
    localparam int LB   = $clog2(ROW_MAX);
    localparam int NB   = $clog2(ROW_MAX + 1);
    localparam int SUMW = SB + LB;
    localparam int SQW  = 2 * SB + LB;
    localparam int VW   = NB + SQW;
    localparam int VARW = 2 * SB;
    localparam int QM   = DIG_BITS * ((SB + DIG_BITS - 1) / DIG_BITS);
    localparam int QV   = DIG_BITS * ((VARW + DIG_BITS - 1) / DIG_BITS);
    localparam int QW   = QV;
    localparam int DENW = (2 * NB > SB + 2) ? 2 * NB : SB + 2;
    localparam int RW   = DENW + 1;
    localparam int NUMW = VW + 16;
    localparam int CW   = $clog2(QV / DIG_BITS + 1);

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_MUL   = 4'd1;
    localparam logic [3:0] S_MEANW = 4'd2;
    localparam logic [3:0] S_VAR   = 4'd3;
    localparam logic [3:0] S_VARW  = 4'd4;
    localparam logic [3:0] S_SQRT  = 4'd5;
    localparam logic [3:0] S_RD    = 4'd6;
    localparam logic [3:0] S_ZCALC = 4'd7;
    localparam logic [3:0] S_ZW    = 4'd8;
    localparam logic [3:0] S_PUT   = 4'd9;

    localparam logic signed [NORM_W-1:0] Z_MAX = {1'b0, {(NORM_W-1){1'b1}}};
    localparam logic signed [NORM_W-1:0] Z_MIN = {1'b1, {(NORM_W-1){1'b0}}};

    logic [3:0]             r_state;
    logic                   r_bank;
    logic [NB-1:0]          r_n;
    logic signed [SUMW-1:0] r_sum;
    logic [SQW-1:0]         r_sq;
    logic [VW-1:0]          r_nq;
    logic [VW-1:0]          r_s2;
    logic [VW-1:0]          r_v;
    logic signed [SB-1:0]   r_mean;
    logic [VARW-1:0]        r_rad, r_res, r_bit;
    logic [VARW-1:0]        n_rad, n_res, n_bit;
    logic [SB-1:0]          r_std;
    logic [NB-1:0]          r_k;
    logic                   r_neg;
    logic signed [NORM_W-1:0] r_z;
    logic                   r_ovalid;
    logic signed [NORM_W-1:0] r_onorm;
    logic                   r_olast;
    logic                   r_oflat;

    logic                   d_bank;
    logic [NB-1:0]          d_n;
    logic signed [SUMW-1:0] d_sum;
    logic [SQW-1:0]         d_sq;
    logic [SUMW-1:0]        abs_sum;
    logic signed [SB:0]     diff;
    logic [SB:0]            abs_diff;
    logic [NUMW-1:0]        z_num;
    logic                   z_sat;
    logic                   flat;
    logic                   slot_free;
    logic                   put_last;
    logic [SB-1:0]          mean_mag;
    logic [QZ_BITS-1:0]     z_mag;

    logic                   dv_start;
    logic [NUMW-1:0]        dv_num;
    logic [RW-1:0]          dv_rem;
    logic [QW-1:0]          dv_bits;
    logic [DENW-1:0]        dv_den;
    logic [CW-1:0]          dv_digits;
    logic                   dv_done;
    logic [QW-1:0]          dv_quo;

    assign {d_bank, d_n, d_sum, d_sq} = i_desc;

    assign abs_sum  = r_sum[SUMW-1] ? SUMW'(-r_sum) : SUMW'(r_sum);
    assign diff     = $signed({i_rdata[SB-1], i_rdata}) - $signed({r_mean[SB-1], r_mean});
    assign abs_diff = diff[SB] ? (SB+1)'(-diff) : (SB+1)'(diff);
    assign z_num    = (NUMW'(abs_diff) << 13) + NUMW'(r_std);
    assign z_sat    = (z_num >= (NUMW'(r_std) << 16));
    assign flat     = (r_std == '0);
    assign slot_free = !r_ovalid || i_ready;
    assign put_last = (r_state == S_PUT) && slot_free && (r_k + 1'b1 == r_n);
    assign mean_mag = dv_quo[SB-1:0];
    assign z_mag    = dv_quo[QZ_BITS-1:0];

    // Operand alignment per division: the remainder takes the bits above the
    // quotient field, the rest is shifted in from the top.
    always_comb begin
        dv_start  = 1'b0;
        dv_num    = '0;
        dv_den    = '0;
        dv_rem    = '0;
        dv_bits   = '0;
        dv_digits = '0;
        unique case (r_state)
            S_MUL: begin
                dv_start  = 1'b1;
                dv_num    = (NUMW'(abs_sum) << 1) + NUMW'(r_n);
                dv_den    = DENW'({r_n, 1'b0});
                dv_rem    = RW'(dv_num >> QM);
                dv_bits   = QW'(dv_num << (QW - QM));
                dv_digits = CW'(QM / DIG_BITS);
            end
            S_VAR: begin
                dv_start  = 1'b1;
                dv_num    = NUMW'(r_v);
                dv_den    = DENW'(r_n) * DENW'(r_n);
                dv_rem    = RW'(dv_num >> QV);
                dv_bits   = QW'(dv_num << (QW - QV));
                dv_digits = CW'(QV / DIG_BITS);
            end
            S_ZCALC: begin
                dv_start  = !flat && !z_sat;
                dv_num    = z_num;
                dv_den    = DENW'({r_std, 1'b0});
                dv_rem    = RW'(dv_num >> QZ_BITS);
                dv_bits   = QW'(dv_num << (QW - QZ_BITS));
                dv_digits = CW'(QZ_BITS / DIG_BITS);
            end
            default: begin
                dv_start = 1'b0;
            end
        endcase
    end

    // One result bit of the square root per cycle.
    always_comb begin
        n_rad = r_rad;
        n_res = r_res >> 1;
        if (r_rad >= r_res + r_bit) begin
            n_rad = r_rad - (r_res + r_bit);
            n_res = (r_res >> 1) + r_bit;
        end
        n_bit = r_bit >> 2;
    end

    rzn_div #(
        .RW (RW),
        .QW (QW),
        .CW (CW)
    ) u_div (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_start  (dv_start),
        .i_rem    (dv_rem),
        .i_bits   (dv_bits),
        .i_den    (dv_den),
        .i_digits (dv_digits),
        .o_done   (dv_done),
        .o_quo    (dv_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state  <= S_IDLE;
            r_ovalid <= 1'b0;
            r_k      <= '0;
            r_std    <= '0;
            r_mean   <= '0;
        end else begin
            if (r_ovalid && i_ready) begin
                r_ovalid <= 1'b0;
            end
            unique case (r_state)
                S_IDLE: begin
                    if (!i_empty) begin
                        r_state <= S_MUL;
                    end
                end
                S_MUL: begin
                    r_state <= S_MEANW;
                end
                S_MEANW: begin
                    if (dv_done) begin
                        r_mean  <= r_sum[SUMW-1] ? SB'(-mean_mag) : SB'(mean_mag);
                        r_state <= S_VAR;
                    end
                end
                S_VAR: begin
                    r_state <= S_VARW;
                end
                S_VARW: begin
                    if (dv_done) begin
                        r_state <= S_SQRT;
                    end
                end
                S_SQRT: begin
                    if (n_bit == '0) begin
                        r_std   <= n_res[SB-1:0];
                        r_k     <= '0;
                        r_state <= S_RD;
                    end
                end
                S_RD: begin
                    r_state <= S_ZCALC;
                end
                S_ZCALC: begin
                    r_state <= (flat || z_sat) ? S_PUT : S_ZW;
                end
                S_ZW: begin
                    if (dv_done) begin
                        r_state <= S_PUT;
                    end
                end
                S_PUT: begin
                    if (slot_free) begin
                        r_ovalid <= 1'b1;
                        if (put_last) begin
                            r_state <= S_IDLE;
                        end else begin
                            r_k     <= r_k + 1'b1;
                            r_state <= S_RD;
                        end
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    // Datapath registers, no reset needed.
    always_ff @(posedge i_clk) begin
        if (o_pop) begin
            r_bank <= d_bank;
            r_n    <= d_n;
            r_sum  <= d_sum;
            r_sq   <= d_sq;
        end
        if (r_state == S_MUL) begin
            r_s2 <= VW'(abs_sum) * VW'(abs_sum);
            r_nq <= VW'(r_n) * VW'(r_sq);
        end
        if (r_state == S_MEANW) begin
            r_v <= r_nq - r_s2;
        end
        if ((r_state == S_VARW) && dv_done) begin
            r_rad <= dv_quo[VARW-1:0];
            r_res <= '0;
            r_bit <= VARW'(1) << (VARW - 2);
        end
        if (r_state == S_SQRT) begin
            r_rad <= n_rad;
            r_res <= n_res;
            r_bit <= n_bit;
        end
        if (r_state == S_ZCALC) begin
            r_neg <= diff[SB];
            if (flat) begin
                r_z <= '0;
            end else if (z_sat) begin
                r_z <= diff[SB] ? Z_MIN : Z_MAX;
            end
        end
        if ((r_state == S_ZW) && dv_done) begin
            r_z <= r_neg ? NORM_W'(-z_mag) : NORM_W'(z_mag);
        end
        if ((r_state == S_PUT) && slot_free) begin
            r_onorm <= r_z;
            r_olast <= put_last;
            r_oflat <= flat;
        end
    end

    assign o_pop        = (r_state == S_IDLE) && !i_empty;
    assign o_raddr      = {r_bank, r_k[LB-1:0]};
    assign o_row_done   = put_last;
    assign o_valid      = r_ovalid;
    assign o_norm_value = r_onorm;
    assign o_row_last   = r_olast;
    assign o_flat_row   = r_oflat;

    `RZN_ASSERT_NOW(a_flat_zero, r_ovalid && r_oflat, r_onorm == '0, "flat row gave nonzero value")
    `RZN_ASSERT_NEXT(a_last_idle, put_last, (r_state == S_IDLE) && r_ovalid && r_olast, "row end not taken")
    `RZN_ASSERT_NOW(a_k_range, r_state == S_ZCALC, r_k < r_n, "sample index past row end")

endmodule

// ===== rtl/row_zscore_normalizer.sv =====
// A row closes on its last sample; its first result follows the mean divide, the variance
// divide, the square root and the first normalizing divide in the back end.
// Throughput: samples enter at one per cycle while one of the two row-store banks is free;
// results come one at a time, each after a Q4.12 divide in the shared divider unless flat or saturated.
// Reset (synchronous, active low) empties the row and the queue and sets row_length to 64.
// Depends on rzn_pkg, rzn_ram, rzn_queue, rzn_front and rzn_back.
module row_zscore_normalizer
    import rzn_pkg::*;
#(
    parameter int ROW_MAX     = 64,
    parameter int SAMPLE_BITS = 16
) (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_cfg_we,
    input  logic [CFG_W-1:0]              i_cfg_data,
    input  logic                          i_valid,
    output logic                          o_ready,
    input  logic signed [SAMPLE_BITS-1:0] i_sample,
    output logic                          o_valid,
    input  logic                          i_ready,
    output logic signed [NORM_W-1:0]      o_norm_value,
    output logic                          o_row_last,
    output logic                          o_flat_row
);

    localparam int LB    = $clog2(ROW_MAX);
    localparam int NB    = $clog2(ROW_MAX + 1);
    localparam int DESCW = 1 + NB + 3 * SAMPLE_BITS + 2 * LB;

    logic [CFG_W-1:0]       r_row_len;
    logic                   ram_we;
    logic [LB:0]            ram_waddr;
    logic [LB:0]            ram_raddr;
    logic [SAMPLE_BITS-1:0] ram_wdata;
    logic [SAMPLE_BITS-1:0] ram_rdata;
    logic                   q_push;
    logic                   q_pop;
    logic                   q_empty;
    logic [DESCW-1:0]       q_in;
    logic [DESCW-1:0]       q_out;
    logic                   row_done;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_row_len <= CFG_RST;
        end else if (i_cfg_we) begin
            r_row_len <= i_cfg_data;
        end
    end

    rzn_ram #(
        .W     (SAMPLE_BITS),
        .DEPTH (2 ** (LB + 1))
    ) u_ram (
        .i_clk   (i_clk),
        .i_we    (ram_we),
        .i_waddr (ram_waddr),
        .i_wdata (ram_wdata),
        .i_raddr (ram_raddr),
        .o_rdata (ram_rdata)
    );

    rzn_queue #(
        .W (DESCW)
    ) u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (q_push),
        .i_data  (q_in),
        .i_pop   (q_pop),
        .o_data  (q_out),
        .o_empty (q_empty)
    );

    rzn_front #(
        .ROW_MAX     (ROW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_row_len  (r_row_len),
        .i_valid    (i_valid),
        .o_ready    (o_ready),
        .i_sample   (i_sample),
        .o_we       (ram_we),
        .o_waddr    (ram_waddr),
        .o_wdata    (ram_wdata),
        .o_push     (q_push),
        .o_desc     (q_in),
        .i_row_done (row_done)
    );

    rzn_back #(
        .ROW_MAX     (ROW_MAX),
        .SAMPLE_BITS (SAMPLE_BITS)
    ) u_back (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_empty      (q_empty),
        .i_desc       (q_out),
        .o_pop        (q_pop),
        .o_raddr      (ram_raddr),
        .i_rdata      (ram_rdata),
        .o_row_done   (row_done),
        .i_ready      (i_ready),
        .o_valid      (o_valid),
        .o_norm_value (o_norm_value),
        .o_row_last   (o_row_last),
        .o_flat_row   (o_flat_row)
    );

endmodule
